// ===== rtl/shh_pkg.sv =====
// shared types, codes and defaults of the start/stop interval histogrammer
// no dependencies; imported by every other file of the block but shh_ram
package shh_pkg;

  localparam int NUM_BINS_DEF    = 128;
  localparam int TIME_WIDTH_DEF  = 48;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int KIND_W     = 2;
  localparam int READ_BIN_W = 7;
  localparam int SHIFT_W    = 4;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_EVENT = 2'd0;
  localparam kind_t KIND_READ  = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;

  typedef logic [1:0] evclass_t;
  localparam evclass_t CLS_IGNORED = 2'd0;
  localparam evclass_t CLS_START   = 2'd1;
  localparam evclass_t CLS_STOP1   = 2'd2;
  localparam evclass_t CLS_STOP2   = 2'd3;

  typedef logic [CFG_AW-3:0] reg_idx_t;
  localparam reg_idx_t REG_BIN_SHIFT = 1'b0;

  // histogram path controls for one item
  typedef struct packed {
    logic inc;
    logic lookup;
    logic clear;
  } hist_ctl_t;

endpackage

// ===== rtl/shh_if.sv =====
// valid/ready stream interfaces for input items and result items
// depends on shh_pkg
interface shh_in_if
  import shh_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  kind_t                 kind;
  logic                  chan_start;
  logic                  chan_stop_one;
  logic                  chan_stop_two;
  logic [TIME_WIDTH-1:0] event_time;
  logic                  read_channel;
  logic [READ_BIN_W-1:0] read_bin;

  modport source (
    output valid, kind, chan_start, chan_stop_one, chan_stop_two, event_time,
           read_channel, read_bin,
    input  ready
  );
  modport sink (
    input  valid, kind, chan_start, chan_stop_one, chan_stop_two, event_time,
           read_channel, read_bin,
    output ready
  );
endinterface

interface shh_out_if
  import shh_pkg::*;
#(
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  evclass_t               event_class;
  logic                   matched;
  logic [TIME_WIDTH-1:0]  interval;
  logic                   in_range;
  logic [COUNT_WIDTH-1:0] bin_count;
  logic [COUNT_WIDTH-1:0] overflow_total;
  logic [COUNT_WIDTH-1:0] starts_matched_one;
  logic [COUNT_WIDTH-1:0] starts_matched_two;

  modport source (
    output valid, event_class, matched, interval, in_range, bin_count,
           overflow_total, starts_matched_one, starts_matched_two,
    input  ready
  );
  modport sink (
    input  valid, event_class, matched, interval, in_range, bin_count,
           overflow_total, starts_matched_one, starts_matched_two,
    output ready
  );
endinterface

// ===== rtl/shh_ram.sv =====
// generic single-write, single-read RAM with registered read data
// no dependencies
module shh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/shh_cfg.sv =====
// apb-style register port holding bin_shift
// depends on shh_pkg
module shh_cfg
  import shh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [SHIFT_W-1:0] bin_shift
);

  logic [SHIFT_W-1:0] bin_shift_r, bin_shift_nxt;
  reg_idx_t           reg_idx;
  logic               wr_xfer;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign pready  = 1'b1;
  assign wr_xfer = psel && penable && pwrite && pready;

  always_comb begin
    bin_shift_nxt = bin_shift_r;
    if (wr_xfer && reg_idx == REG_BIN_SHIFT) begin
      bin_shift_nxt = pwdata[SHIFT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_BIN_SHIFT) begin
      prdata = CFG_DW'(bin_shift_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_shift_r <= '0;
    end else begin
      bin_shift_r <= bin_shift_nxt;
    end
  end

  assign bin_shift = bin_shift_r;

endmodule

// ===== rtl/shh_front.sv =====
// input register, event classification, interval and bin computation,
// window and counter state; depends on shh_pkg and shh_if
module shh_front
  import shh_pkg::*;
#(
  parameter int NUM_BINS    = NUM_BINS_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int BW = $clog2(NUM_BINS),
  localparam int AW = $clog2(2 * NUM_BINS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  shh_in_if.sink                 in_s,
  input  logic [SHIFT_W-1:0]     bin_shift,
  input  logic                   take,
  output logic                   a_valid,
  output evclass_t               a_class,
  output logic                   a_matched,
  output logic [TIME_WIDTH-1:0]  a_interval,
  output logic                   a_in_range,
  output logic [COUNT_WIDTH-1:0] a_ovf,
  output logic [COUNT_WIDTH-1:0] a_msc_one,
  output logic [COUNT_WIDTH-1:0] a_msc_two,
  output hist_ctl_t              a_ctl,
  output logic [AW-1:0]          a_addr
);

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  logic                  a_v_r;
  kind_t                 kind_r;
  logic                  c0_r, c1_r, c2_r;
  logic [TIME_WIDTH-1:0] t_r;
  logic                  rch_r;
  logic [READ_BIN_W-1:0] rbin_r;

  logic [TIME_WIDTH-1:0]  start_t_r, start_t_nxt;
  logic                   seen_r, seen_nxt;
  logic [1:0]             whs_r, whs_nxt;
  logic [COUNT_WIDTH-1:0] msc_one_r, msc_one_nxt, msc_two_r, msc_two_nxt;
  logic [COUNT_WIDTH-1:0] ovf_one_r, ovf_one_nxt, ovf_two_r, ovf_two_nxt;

  logic                  is_ev, is_read, is_clear, is_start, is_stop, match;
  logic                  ch, sel_ch, ev_inr, rd_inr;
  logic [TIME_WIDTH-1:0] diff, shifted;
  logic [BW-1:0]         idx;

  assign in_s.ready = !a_v_r || take;
  assign a_valid    = a_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_s.valid && in_s.ready) begin
      a_v_r <= 1'b1;
    end else if (take) begin
      a_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      kind_r <= in_s.kind;
      c0_r   <= in_s.chan_start;
      c1_r   <= in_s.chan_stop_one;
      c2_r   <= in_s.chan_stop_two;
      t_r    <= in_s.event_time;
      rch_r  <= in_s.read_channel;
      rbin_r <= in_s.read_bin;
    end
  end

  always_comb begin
    is_ev    = kind_r == KIND_EVENT;
    is_read  = kind_r == KIND_READ;
    is_clear = kind_r == KIND_CLEAR;
    is_start = is_ev && c0_r && !c1_r && !c2_r;
    is_stop  = is_ev && !c0_r && (c1_r ^ c2_r);
    ch       = c2_r;
    diff     = t_r - start_t_r;
    shifted  = diff >> bin_shift;
    ev_inr   = shifted < TIME_WIDTH'(NUM_BINS);
    match    = is_stop && seen_r && (t_r >= start_t_r);
    rd_inr   = 32'(rbin_r) < 32'(NUM_BINS);
    sel_ch   = is_read ? rch_r : ch;
    idx      = is_read ? BW'(rbin_r) : shifted[BW-1:0];
    a_addr   = sel_ch ? AW'(NUM_BINS) + AW'(idx) : AW'(idx);
  end

  // state after this item
  always_comb begin
    start_t_nxt = start_t_r;
    seen_nxt    = seen_r;
    whs_nxt     = whs_r;
    msc_one_nxt = msc_one_r;
    msc_two_nxt = msc_two_r;
    ovf_one_nxt = ovf_one_r;
    ovf_two_nxt = ovf_two_r;
    case (kind_r)
      KIND_EVENT: begin
        if (is_start) begin
          start_t_nxt = t_r;
          seen_nxt    = 1'b1;
          whs_nxt     = '0;
        end
        if (match) begin
          if (!ev_inr) begin
            if (ch) begin
              ovf_two_nxt = sat_inc(ovf_two_r);
            end else begin
              ovf_one_nxt = sat_inc(ovf_one_r);
            end
          end
          if (!whs_r[ch]) begin
            whs_nxt[ch] = 1'b1;
            if (ch) begin
              msc_two_nxt = sat_inc(msc_two_r);
            end else begin
              msc_one_nxt = sat_inc(msc_one_r);
            end
          end
        end
      end
      KIND_CLEAR: begin
        start_t_nxt = '0;
        seen_nxt    = 1'b0;
        whs_nxt     = '0;
        msc_one_nxt = '0;
        msc_two_nxt = '0;
        ovf_one_nxt = '0;
        ovf_two_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_t_r <= '0;
      seen_r    <= 1'b0;
      whs_r     <= '0;
      msc_one_r <= '0;
      msc_two_r <= '0;
      ovf_one_r <= '0;
      ovf_two_r <= '0;
    end else if (a_v_r && take) begin
      start_t_r <= start_t_nxt;
      seen_r    <= seen_nxt;
      whs_r     <= whs_nxt;
      msc_one_r <= msc_one_nxt;
      msc_two_r <= msc_two_nxt;
      ovf_one_r <= ovf_one_nxt;
      ovf_two_r <= ovf_two_nxt;
    end
  end

  always_comb begin
    if (is_start) begin
      a_class = CLS_START;
    end else if (is_stop) begin
      a_class = ch ? CLS_STOP2 : CLS_STOP1;
    end else begin
      a_class = CLS_IGNORED;
    end
    a_matched    = match;
    a_interval   = match ? diff : '0;
    a_in_range   = is_read ? rd_inr : (match && ev_inr);
    a_ovf        = is_read ? (rch_r ? ovf_two_r : ovf_one_r) : '0;
    a_msc_one    = msc_one_nxt;
    a_msc_two    = msc_two_nxt;
    a_ctl.inc    = match && ev_inr;
    a_ctl.lookup = is_read && rd_inr;
    a_ctl.clear  = is_clear;
  end

endmodule

// ===== rtl/shh_hist.sv =====
// histogram store: bin ram, per-entry valid bits, read-modify-write with bypass
// depends on shh_pkg and shh_ram
module shh_hist
  import shh_pkg::*;
#(
  parameter int NUM_BINS    = NUM_BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int DEPTH = 2 * NUM_BINS,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   issue,
  input  hist_ctl_t              ctl,
  input  logic [AW-1:0]          addr,
  input  logic                   retire,
  output logic [COUNT_WIDTH-1:0] count
);

  hist_ctl_t              ctl_b_r;
  logic [AW-1:0]          addr_b_r;
  logic                   fwd_hit_r;
  logic [COUNT_WIDTH-1:0] fwd_data_r;
  logic [DEPTH-1:0]       vld_r, vld_nxt;

  logic                   wr_en;
  logic [COUNT_WIDTH-1:0] ram_q, cur, inc_val;

  shh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr_b_r),
    .wr_data (inc_val),
    .rd_en   (issue),
    .rd_addr (addr),
    .rd_data (ram_q)
  );

  always_comb begin
    if (fwd_hit_r) begin
      cur = fwd_data_r;
    end else if (vld_r[addr_b_r]) begin
      cur = ram_q;
    end else begin
      cur = '0;
    end
    inc_val = (&cur) ? cur : cur + 1'b1;
    wr_en   = retire && ctl_b_r.inc;
    count   = ctl_b_r.lookup ? cur : '0;
  end

  always_comb begin
    vld_nxt = vld_r;
    if (retire && ctl_b_r.clear) begin
      vld_nxt = '0;
    end else if (wr_en) begin
      vld_nxt[addr_b_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      ctl_b_r   <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (issue) begin
        ctl_b_r   <= ctl;
        fwd_hit_r <= wr_en && (addr_b_r == addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      addr_b_r   <= addr;
      fwd_data_r <= inc_val;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (retire && ctl_b_r.clear) |=> (vld_r == '0))
    else $error("valid bits not cleared after clear transfer");

  a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(addr_b_r)])
    else $error("written bin not marked valid");

  a_bypass_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && wr_en && (addr_b_r == addr)) |=> fwd_hit_r)
    else $error("back-to-back update of one bin missed the bypass");
`endif

endmodule

// ===== rtl/start_stop_interval_histogrammer.sv =====
// start/stop interval histogrammer top level
// a result passes the input register, the histogram read stage and the output
// register in that order before it is offered
// throughput: one item per cycle unless out_s stalls; bin ram updated
// read-modify-write with bypass; reset: control state, counters and histogram
// valid bits clear at once, no clearing pass; bin_shift resets to 0
module start_stop_interval_histogrammer
  import shh_pkg::*;
#(
  parameter int NUM_BINS    = NUM_BINS_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  shh_in_if.sink             in_s,
  shh_out_if.source          out_s,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  localparam int AW = $clog2(2 * NUM_BINS);

  logic [SHIFT_W-1:0]     bin_shift;
  logic                   a_valid, en_b, en_c;
  evclass_t               a_class;
  logic                   a_matched, a_in_range;
  logic [TIME_WIDTH-1:0]  a_interval;
  logic [COUNT_WIDTH-1:0] a_ovf, a_msc_one, a_msc_two, hist_count;
  hist_ctl_t              a_ctl;
  logic [AW-1:0]          a_addr;

  logic                   b_v_r;
  evclass_t               b_class_r;
  logic                   b_matched_r, b_in_range_r;
  logic [TIME_WIDTH-1:0]  b_interval_r;
  logic [COUNT_WIDTH-1:0] b_ovf_r, b_msc_one_r, b_msc_two_r;

  logic                   c_v_r;
  evclass_t               c_class_r;
  logic                   c_matched_r, c_in_range_r;
  logic [TIME_WIDTH-1:0]  c_interval_r;
  logic [COUNT_WIDTH-1:0] c_count_r, c_ovf_r, c_msc_one_r, c_msc_two_r;

  shh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .bin_shift (bin_shift)
  );

  shh_front #(
    .NUM_BINS    (NUM_BINS),
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_s),
    .bin_shift  (bin_shift),
    .take       (en_b),
    .a_valid    (a_valid),
    .a_class    (a_class),
    .a_matched  (a_matched),
    .a_interval (a_interval),
    .a_in_range (a_in_range),
    .a_ovf      (a_ovf),
    .a_msc_one  (a_msc_one),
    .a_msc_two  (a_msc_two),
    .a_ctl      (a_ctl),
    .a_addr     (a_addr)
  );

  shh_hist #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (a_valid && en_b),
    .ctl    (a_ctl),
    .addr   (a_addr),
    .retire (b_v_r && en_c),
    .count  (hist_count)
  );

  assign en_c = !c_v_r || out_s.ready;
  assign en_b = !b_v_r || en_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (en_b) begin
        b_v_r <= a_valid;
      end
      if (en_c) begin
        c_v_r <= b_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && en_b) begin
      b_class_r    <= a_class;
      b_matched_r  <= a_matched;
      b_interval_r <= a_interval;
      b_in_range_r <= a_in_range;
      b_ovf_r      <= a_ovf;
      b_msc_one_r  <= a_msc_one;
      b_msc_two_r  <= a_msc_two;
    end
    if (b_v_r && en_c) begin
      c_class_r    <= b_class_r;
      c_matched_r  <= b_matched_r;
      c_interval_r <= b_interval_r;
      c_in_range_r <= b_in_range_r;
      c_count_r    <= hist_count;
      c_ovf_r      <= b_ovf_r;
      c_msc_one_r  <= b_msc_one_r;
      c_msc_two_r  <= b_msc_two_r;
    end
  end

  assign out_s.valid              = c_v_r;
  assign out_s.event_class        = c_class_r;
  assign out_s.matched            = c_matched_r;
  assign out_s.interval           = c_interval_r;
  assign out_s.in_range           = c_in_range_r;
  assign out_s.bin_count          = c_count_r;
  assign out_s.overflow_total     = c_ovf_r;
  assign out_s.starts_matched_one = c_msc_one_r;
  assign out_s.starts_matched_two = c_msc_two_r;

endmodule
